/* design/merge_sort_engine_assert.svh */
`ifndef MERGE_SORT_ENGINE_ASSERT_SVH
`define MERGE_SORT_ENGINE_ASSERT_SVH

// check prop in the same cycle that trig holds
`define MSE_ASSERT_IMP(lbl, clk, rstn, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (prop)) \
    else $error("merge sort engine check failed");

// check prop in the cycle after trig holds
`define MSE_ASSERT_NXT(lbl, clk, rstn, trig, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (prop)) \
    else $error("merge sort engine check failed");

`endif

/* design/mse_pkg.sv */
package mse_pkg;

  localparam int unsigned DataW        = 32;
  localparam int unsigned DepthDefault = 64;
  localparam int unsigned MaxCntW      = 7;
  localparam int unsigned QDepth       = 2;

  typedef struct packed {
    logic [MaxCntW-1:0] count;
  } cmd_t;

endpackage

/* design/merge_sort_engine.sv */
// Load: one word per cycle while s_axis_tready_o is high; the set closes on tlast or when
//   DEPTH words are in. Sort: ceil(log2(n)) merge passes over two ping-pong RAMs; each
//   element goes through S_RD and S_WR and each run pair through S_SETUP (dual read port,
//   registered read, one write). Drain: S_OUT_RD, S_OUT_LD and S_OUT_HOLD per sorted word,
//   held in S_OUT_HOLD while m_axis_tready_i is low. One set is handled at a time.
// Reset clears FSM, valid, busy and FIFO flops; RAM is not cleared; unwritten words unused.
module merge_sort_engine import mse_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [DataW-1:0] s_axis_tdata_i,   // [31:0] value
  input  logic             s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [DataW-1:0] m_axis_tdata_o,   // [31:0] sorted_value
  output logic             m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic             f_we, b_we_a, b_we_b;
  logic [AW-1:0]    f_waddr, b_waddr, b_raddr0, b_raddr1;
  logic [DataW-1:0] f_wdata, b_wdata;
  logic             push, full, pop, empty, done;
  cmd_t             push_cmd, pop_cmd;
  logic             a_we;
  logic [AW-1:0]    a_waddr;
  logic [DataW-1:0] a_wdata;
  logic [DataW-1:0] rda0, rda1, rdb0, rdb1;

  assign a_we    = f_we || b_we_a;
  assign a_waddr = f_we ? f_waddr : b_waddr;
  assign a_wdata = f_we ? f_wdata : b_wdata;

  mse_front #(.DEPTH(DEPTH)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .we_o            (f_we),
    .waddr_o         (f_waddr),
    .wdata_o         (f_wdata),
    .push_o          (push),
    .push_cmd_o      (push_cmd),
    .full_i          (full),
    .done_i          (done)
  );

  mse_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty)
  );

  mse_ram #(.Width(DataW), .Depth(DEPTH)) u_ram_a (
    .clk_i    (clk_i),
    .we_i     (a_we),
    .waddr_i  (a_waddr),
    .wdata_i  (a_wdata),
    .raddr0_i (b_raddr0),
    .raddr1_i (b_raddr1),
    .rdata0_o (rda0),
    .rdata1_o (rda1)
  );

  mse_ram #(.Width(DataW), .Depth(DEPTH)) u_ram_b (
    .clk_i    (clk_i),
    .we_i     (b_we_b),
    .waddr_i  (b_waddr),
    .wdata_i  (b_wdata),
    .raddr0_i (b_raddr0),
    .raddr1_i (b_raddr1),
    .rdata0_o (rdb0),
    .rdata1_o (rdb1)
  );

  mse_back #(.DEPTH(DEPTH)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .cmd_i           (pop_cmd),
    .pop_o           (pop),
    .done_o          (done),
    .we_a_o          (b_we_a),
    .we_b_o          (b_we_b),
    .waddr_o         (b_waddr),
    .wdata_o         (b_wdata),
    .raddr0_o        (b_raddr0),
    .raddr1_o        (b_raddr1),
    .rda0_i          (rda0),
    .rda1_i          (rda1),
    .rdb0_i          (rdb0),
    .rdb1_i          (rdb1),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

/* design/mse_ram.sv */
module mse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata0_o,
  output logic [Width-1:0]         rdata1_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata0_q;
  logic [Width-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

/* design/mse_front.sv */
module mse_front import mse_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [DataW-1:0]         s_axis_tdata_i,
  input  logic                     s_axis_tlast_i,
  output logic                     we_o,
  output logic [$clog2(DEPTH)-1:0] waddr_o,
  output logic [DataW-1:0]         wdata_o,
  output logic                     push_o,
  output cmd_t                     push_cmd_o,
  input  logic                     full_i,
  input  logic                     done_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_q, count_d, count_inc;
  logic          busy_q, busy_d;
  logic          accept;

  assign s_axis_tready_o = !busy_q && !full_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign count_inc       = count_q + CW'(1);

  assign we_o    = accept;
  assign waddr_o = count_q[AW-1:0];
  assign wdata_o = s_axis_tdata_i;

  always_comb begin
    count_d          = count_q;
    busy_d           = busy_q;
    push_o           = 1'b0;
    push_cmd_o.count = MaxCntW'(count_inc);
    if (done_i) begin
      busy_d = 1'b0;
    end
    if (accept) begin
      if (s_axis_tlast_i || (count_inc == CW'(DEPTH))) begin
        push_o  = 1'b1;
        count_d = '0;
        busy_d  = 1'b1;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
    end
  end

endmodule

/* design/mse_cmd_fifo.sv */
module mse_cmd_fifo import mse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o
);

  localparam int unsigned PW = $clog2(QDepth);
  localparam int unsigned FW = $clog2(QDepth + 1);

  cmd_t          slot_q [QDepth];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [FW-1:0] fill_q;

  assign full_o    = (fill_q == FW'(QDepth));
  assign empty_o   = (fill_q == '0);
  assign pop_cmd_o = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      slot_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wptr_q <= (wptr_q == PW'(QDepth - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i && !empty_o) begin
        rptr_q <= (rptr_q == PW'(QDepth - 1)) ? '0 : rptr_q + PW'(1);
      end
      case ({push_i && !full_o, pop_i && !empty_o})
        2'b10:   fill_q <= fill_q + FW'(1);
        2'b01:   fill_q <= fill_q - FW'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

/* design/mse_back.sv */
module mse_back import mse_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  cmd_t                     cmd_i,
  output logic                     pop_o,
  output logic                     done_o,
  output logic                     we_a_o,
  output logic                     we_b_o,
  output logic [$clog2(DEPTH)-1:0] waddr_o,
  output logic [DataW-1:0]         wdata_o,
  output logic [$clog2(DEPTH)-1:0] raddr0_o,
  output logic [$clog2(DEPTH)-1:0] raddr1_o,
  input  logic [DataW-1:0]         rda0_i,
  input  logic [DataW-1:0]         rda1_i,
  input  logic [DataW-1:0]         rdb0_i,
  input  logic [DataW-1:0]         rdb1_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  output logic [DataW-1:0]         m_axis_tdata_o,
  output logic                     m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = CW + 2;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SETUP    = 7'b0000010,
    S_RD       = 7'b0000100,
    S_WR       = 7'b0001000,
    S_OUT_RD   = 7'b0010000,
    S_OUT_LD   = 7'b0100000,
    S_OUT_HOLD = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] n_q, n_d, lo_q, lo_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CW-1:0] mid_q, mid_d, hi_q, hi_d, k_inc;
  logic [EW-1:0] w_q, w_d, w2, mid_sum, hi_sum;
  logic          src_q, src_d;
  logic [DataW-1:0] rd_i, rd_j;
  logic          take_i;
  logic          out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [DataW-1:0] out_data_q, out_data_d;

  assign rd_i    = src_q ? rdb0_i : rda0_i;
  assign rd_j    = src_q ? rdb1_i : rda1_i;
  assign take_i  = (i_q < mid_q) && ((j_q >= hi_q) || ($signed(rd_i) <= $signed(rd_j)));
  assign k_inc   = k_q + CW'(1);
  assign w2      = w_q << 1;
  assign mid_sum = EW'(lo_q) + w_q;
  assign hi_sum  = EW'(lo_q) + w2;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    lo_d        = lo_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    w_d         = w_q;
    src_d       = src_q;
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_data_d  = out_data_q;
    pop_o       = 1'b0;
    done_o      = 1'b0;
    we_a_o      = 1'b0;
    we_b_o      = 1'b0;
    waddr_o     = k_q[AW-1:0];
    wdata_o     = take_i ? rd_i : rd_j;
    raddr0_o    = i_q[AW-1:0];
    raddr1_o    = j_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          n_d     = cmd_i.count[CW-1:0];
          w_d     = EW'(1);
          lo_d    = '0;
          k_d     = '0;
          src_d   = 1'b0;
          state_d = (cmd_i.count[CW-1:0] == CW'(1)) ? S_OUT_RD : S_SETUP;
        end
      end
      S_SETUP: begin
        i_d     = lo_q;
        k_d     = lo_q;
        mid_d   = (mid_sum > EW'(n_q)) ? n_q : mid_sum[CW-1:0];
        j_d     = (mid_sum > EW'(n_q)) ? n_q : mid_sum[CW-1:0];
        hi_d    = (hi_sum > EW'(n_q)) ? n_q : hi_sum[CW-1:0];
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        we_a_o = src_q;
        we_b_o = !src_q;
        if (take_i) begin
          i_d = i_q + CW'(1);
        end else begin
          j_d = j_q + CW'(1);
        end
        k_d = k_inc;
        if (k_inc == hi_q) begin
          if (hi_q == n_q) begin
            src_d = !src_q;
            w_d   = w2;
            lo_d  = '0;
            if (w2 >= EW'(n_q)) begin
              k_d     = '0;
              state_d = S_OUT_RD;
            end else begin
              state_d = S_SETUP;
            end
          end else begin
            lo_d    = hi_q;
            state_d = S_SETUP;
          end
        end else begin
          state_d = S_RD;
        end
      end
      S_OUT_RD: begin
        raddr0_o = k_q[AW-1:0];
        state_d  = S_OUT_LD;
      end
      S_OUT_LD: begin
        out_data_d  = rd_i;
        out_last_d  = (k_inc == n_q);
        out_valid_d = 1'b1;
        state_d     = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (m_axis_tready_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            done_o  = 1'b1;
            state_d = S_IDLE;
          end else begin
            k_d     = k_inc;
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    lo_q       <= lo_d;
    i_q        <= i_d;
    j_q        <= j_d;
    k_q        <= k_d;
    mid_q      <= mid_d;
    hi_q       <= hi_d;
    w_q        <= w_d;
    src_q      <= src_d;
    out_last_q <= out_last_d;
    out_data_q <= out_data_d;
  end

endmodule

/* design/mse_checker.sv */
`include "merge_sort_engine_assert.svh"

module mse_checker import mse_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             s_axis_tlast_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [DataW-1:0] m_axis_tdata_o,
  input logic             m_axis_tlast_o
);

  logic in_last_word;
  logic out_last_word;
  logic out_stall;

  assign in_last_word  = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;
  assign out_last_word = m_axis_tvalid_o && m_axis_tready_i && m_axis_tlast_o;
  assign out_stall     = m_axis_tvalid_o && !m_axis_tready_i;

  `MSE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall,
                  m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
  `MSE_ASSERT_IMP(a_no_load_while_drain, clk_i, rst_ni, m_axis_tvalid_o, !s_axis_tready_o)
  `MSE_ASSERT_NXT(a_close_set, clk_i, rst_ni, in_last_word, !s_axis_tready_o)
  `MSE_ASSERT_NXT(a_end_of_set, clk_i, rst_ni, out_last_word, !m_axis_tvalid_o)

endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mse_pkg::*;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned ITEMS      = 220;
  localparam int unsigned QUIET_TAIL = 40;
  localparam int unsigned MAX_CYCLES = 200000;
  localparam int unsigned N_ROWS     = 21;

  localparam logic [DataW-1:0] VAL_MAX = 32'h7fff_ffff;
  localparam logic [DataW-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [DataW-1:0] VAL_NEG = 32'hffff_ffff;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             last;
    logic             typed;
    logic [DataW-1:0] want;
  } stim_row_t;

  typedef struct {
    logic [DataW-1:0] value;
    bit               fin;
  } sorted_word_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i = '0;   // [31:0] value
  logic             s_axis_tlast_i = 1'b0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [DataW-1:0] m_axis_tdata_o;        // [31:0] sorted_value
  logic             m_axis_tlast_o;

  logic [DataW-1:0] open_set[$];
  logic [DataW-1:0] sorted_batch[$];
  sorted_word_t     sorted_q[$];

  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  stim_row_t directed_rows [N_ROWS] = '{
    '{VAL_MAX, 1'b1, 1'b1, VAL_MAX},
    '{VAL_MIN, 1'b1, 1'b1, VAL_MIN},
    '{32'd0,   1'b1, 1'b1, 32'd0},
    '{VAL_NEG, 1'b1, 1'b1, VAL_NEG},
    '{VAL_MAX, 1'b0, 1'b0, 32'd0},
    '{VAL_MIN, 1'b0, 1'b0, 32'd0},
    '{32'd0,   1'b0, 1'b0, 32'd0},
    '{VAL_NEG, 1'b0, 1'b0, 32'd0},
    '{32'd1,   1'b0, 1'b0, 32'd0},
    '{32'h8000_0001, 1'b1, 1'b0, 32'd0},
    '{32'd5,   1'b0, 1'b0, 32'd0},
    '{32'd5,   1'b0, 1'b0, 32'd0},
    '{32'hffff_fffb, 1'b0, 1'b0, 32'd0},
    '{32'd5,   1'b0, 1'b0, 32'd0},
    '{32'hffff_fffb, 1'b1, 1'b0, 32'd0},
    '{32'd100, 1'b0, 1'b0, 32'd0},
    '{32'hffff_ff9c, 1'b1, 1'b0, 32'd0},
    '{32'hffff_fffd, 1'b0, 1'b0, 32'd0},
    '{32'hffff_fffe, 1'b0, 1'b0, 32'd0},
    '{VAL_NEG, 1'b0, 1'b0, 32'd0},
    '{32'd0,   1'b1, 1'b0, 32'd0}
  };

  merge_sort_engine #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // collect a word; on close of the set, leave it in ascending order in sorted_batch
  task automatic collect_value(input logic [DataW-1:0] v, input bit l, output bit closed);
    logic [DataW-1:0] key;
    int               j;
    open_set.push_back(v);
    closed = l || (open_set.size() == DEPTH);
    sorted_batch.delete();
    if (closed) begin
      foreach (open_set[i]) begin
        key = open_set[i];
        j = sorted_batch.size();
        while (j > 0 && $signed(sorted_batch[j-1]) > $signed(key)) j--;
        sorted_batch.insert(j, key);
      end
      open_set.delete();
    end
  endtask

  task automatic send_word(input logic [DataW-1:0] v, input bit l, input bit typed,
                           input logic [DataW-1:0] want);
    bit           closed;
    sorted_word_t w;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= v;
    s_axis_tlast_i  <= l;
    do @(posedge clk_i); while (!s_axis_tready_o);
    collect_value(v, l, closed);
    if (closed) begin
      foreach (sorted_batch[k]) begin
        w.value = typed ? want : sorted_batch[k];
        w.fin   = (k == sorted_batch.size() - 1);
        sorted_q.push_back(w);
      end
    end
    words_sent++;
    if (words_sent >= N_ROWS + ITEMS - QUIET_TAIL) quiet = 1'b1;
  endtask

  function automatic logic [DataW-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: return VAL_MAX;
        1: return VAL_MIN;
        2: return 32'd0;
        default: return VAL_NEG;
      endcase
    end
    if (pick <= 2) return $unsigned($signed($urandom_range(0, 16)) - 8);
    return $urandom;
  endfunction

  initial begin
    int unsigned set_idx;
    int unsigned set_len;
    int unsigned pick;
    bit          fill;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_word(directed_rows[r].value, directed_rows[r].last, directed_rows[r].typed,
                directed_rows[r].want);
    end

    set_idx = 0;
    while (words_sent < N_ROWS + ITEMS) begin
      fill = (set_idx == 2);
      pick = $urandom_range(0, 9);
      if (fill) set_len = DEPTH;
      else if (pick < 7) set_len = $urandom_range(1, 8);
      else if (pick < 9) set_len = $urandom_range(9, 24);
      else set_len = $urandom_range(25, 40);
      for (int unsigned i = 0; i < set_len; i++) begin
        send_word(random_value(), !fill && (i == set_len - 1), 1'b0, '0);
      end
      if (set_idx == 4) begin
        // hold off until the block has drained everything
        s_axis_tvalid_i <= 1'b0;
        do @(posedge clk_i); while (sorted_q.size() != 0);
      end
      set_idx++;
    end
    s_axis_tvalid_i <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    sorted_word_t w;
    cycles++;
    if (cycles >= MAX_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (sorted_q.size() == 0) begin
        $error("sorted_value: unexpected word %0d", $signed(m_axis_tdata_o));
        mismatches++;
      end else begin
        w = sorted_q.pop_front();
        if (m_axis_tdata_o !== w.value) begin
          $error("sorted_value: expected %0d, got %0d", $signed(w.value),
                 $signed(m_axis_tdata_o));
          mismatches++;
        end
        if (m_axis_tlast_o !== w.fin) begin
          $error("final_res: expected %0d, got %0d", w.fin, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
    if (quiet) begin
      m_axis_tready_i <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

endmodule
